// ===== design/rkd_pkg.sv =====
`default_nettype none
// Shared types and constants of the repeated k-mer detector.
package rkd_pkg;

  // Fixed field widths.
  localparam int CODE_W = 64;
  localparam int LEN_W  = 6;
  localparam int POS_W  = 8;
  localparam int CNT_W  = 9;
  localparam int BASE_W = 2;

  // The base counter stops here on very long sequences.
  localparam logic [CNT_W-1:0] BASES_SEEN_MAX = 9'd511;

  // k-mer length after reset.
  localparam logic [LEN_W-1:0] LEN_RESET = 6'd10;

  typedef logic [CODE_W-1:0] kmer_t;

  // Sequencer states: take a base, compare, reduce hits, decide and report.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RED,
    ST_DEC
  } state_e;

  // Control that every table cell receives.
  typedef struct packed {
    logic shift_en;
    logic valid;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== design/rkd_cell.sv =====
`default_nettype none
// One table cell: holds one stored k-mer, compares it with the query and
// hands its entry to the next cell when a new k-mer is inserted at the head.
module rkd_cell (
  input  wire logic               clk_i,
  input  wire rkd_pkg::cell_ctrl_t ctrl_i,
  input  wire rkd_pkg::kmer_t     entry_i,
  input  wire rkd_pkg::kmer_t     query_i,
  output rkd_pkg::kmer_t          entry_o,
  output logic                    hit_o
);

  rkd_pkg::kmer_t entry_q;
  logic           hit_q;

  // Shift the chain by one place on an insertion.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift_en) begin
      entry_q <= entry_i;
    end
  end

  // Registered match of a valid entry against the broadcast query.
  always_ff @(posedge clk_i) begin
    hit_q <= ctrl_i.valid && (entry_q == query_i);
  end

  assign entry_o = entry_q;
  assign hit_o   = hit_q;

endmodule
`default_nettype wire

// ===== design/rkd_hit_reduce.sv =====
`default_nettype none
// Registered OR tree over the hit bits of all cells: groups of sixteen are
// combined into registers, and the group results are combined after them.
module rkd_hit_reduce #(
  parameter int DEPTH = 256
) (
  input  wire logic             clk_i,
  input  wire logic [DEPTH-1:0] hit_i,
  output logic                  any_hit_o
);

  localparam int GROUP   = 16;
  localparam int NGROUPS = (DEPTH + GROUP - 1) / GROUP;

  logic [NGROUPS-1:0] group_d;
  logic [NGROUPS-1:0] group_q;

  // First level: one OR per group of cells.
  always_comb begin
    group_d = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      for (int j = 0; j < GROUP; j++) begin
        if (g * GROUP + j < DEPTH) begin
          group_d[g] = group_d[g] | hit_i[g * GROUP + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    group_q <= group_d;
  end

  // Second level over the registered group results.
  assign any_hit_o = |group_q;

endmodule
`default_nettype wire

// ===== design/repeated_kmer_detector_core.sv =====
`default_nettype none
// Channel  Direction  Handshake                 Payload
// input    in         in_valid_i / in_stall_o   base_i, last_i
// result   out        out_valid_o / out_stall_i is_repeat_o, kmer_code_o, start_pos_o,
//                                               end_of_sequence_o, any_repeat_o,
//                                               table_overflow_o
// config   in         cfg_valid_i / cfg_ready_o cfg_data_i (kmer length)
//
// Each base passes through four steps: accept, parallel compare in the cell row,
// registered OR tree, then decision and table update; the next base is taken
// when the sequencer returns to idle.
// A finished result waits in the output register while the next base is taken;
// a stalled output holds the sequencer in its decision step.
// Reset clears the window, counters and flags and sets the length to ten; the
// table cells are not cleared, as the fill count marks which of them are valid.
module repeated_kmer_detector_core #(
  parameter int MAX_KMER    = 32,
  parameter int TABLE_DEPTH = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [rkd_pkg::BASE_W-1:0]  base_i,
  input  wire logic                        last_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             is_repeat_o,
  output logic [rkd_pkg::CODE_W-1:0]       kmer_code_o,
  output logic [rkd_pkg::POS_W-1:0]        start_pos_o,
  output logic                             end_of_sequence_o,
  output logic                             any_repeat_o,
  output logic                             table_overflow_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [rkd_pkg::LEN_W-1:0]   cfg_data_i
);

  localparam int USED_W = $clog2(TABLE_DEPTH + 1);
  localparam int CODE_W = rkd_pkg::CODE_W;
  localparam int LEN_W  = rkd_pkg::LEN_W;
  localparam int CNT_W  = rkd_pkg::CNT_W;
  localparam int POS_W  = rkd_pkg::POS_W;

  rkd_pkg::state_e state_q, state_d;

  logic [LEN_W-1:0]  kmer_len_q;
  rkd_pkg::kmer_t    window_q;
  logic [CNT_W-1:0]  bases_seen_q;
  logic [USED_W-1:0] used_q;
  logic              repeat_found_q;
  logic              overflow_q;
  logic              out_valid_q;

  rkd_pkg::kmer_t    code_q;
  logic [POS_W-1:0]  start_q;
  logic              complete_q;
  logic              last_q;

  logic              in_accept;
  logic              load;
  logic              any_hit;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != rkd_pkg::ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;

  // Effective length, clamped to 1..MAX_KMER.
  logic [LEN_W-1:0] k_eff;
  always_comb begin
    k_eff = (kmer_len_q == '0) ? LEN_W'(1) : kmer_len_q;
    if (k_eff > LEN_W'(MAX_KMER)) begin
      k_eff = LEN_W'(MAX_KMER);
    end
  end

  // New window, counter and the k-mer that ends at the incoming base.
  rkd_pkg::kmer_t    win_new;
  rkd_pkg::kmer_t    code_mask;
  logic [CNT_W-1:0]  cnt_new;
  logic [CNT_W-1:0]  start_full;
  logic              complete_new;

  always_comb begin
    win_new = {window_q[CODE_W-3:0], base_i};
    for (int j = 0; j < CODE_W; j++) begin
      code_mask[j] = (7'(j) < {k_eff, 1'b0});
    end
    cnt_new = (bases_seen_q < rkd_pkg::BASES_SEEN_MAX) ? bases_seen_q + 1'b1
                                                       : bases_seen_q;
    complete_new = (cnt_new >= CNT_W'(k_eff));
    start_full   = cnt_new - CNT_W'(k_eff);
  end

  // Row of table cells; new entries enter at the head.
  rkd_pkg::kmer_t     entry [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] hit;
  logic                   insert;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rkd_pkg::cell_ctrl_t ctrl;
    assign ctrl.shift_en = insert;
    assign ctrl.valid    = (used_q > USED_W'(i));
    if (i == 0) begin : g_head
      rkd_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl),
        .entry_i (code_q),
        .query_i (code_q),
        .entry_o (entry[i]),
        .hit_o   (hit[i])
      );
    end else begin : g_body
      rkd_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl),
        .entry_i (entry[i-1]),
        .query_i (code_q),
        .entry_o (entry[i]),
        .hit_o   (hit[i])
      );
    end
  end

  rkd_hit_reduce #(
    .DEPTH (TABLE_DEPTH)
  ) u_reduce (
    .clk_i     (clk_i),
    .hit_i     (hit),
    .any_hit_o (any_hit)
  );

  // Decision on the current k-mer.
  logic table_full;
  logic rep_now;
  logic ovf_now;
  logic rep_flag;
  logic ovf_flag;

  always_comb begin
    table_full = (used_q >= USED_W'(TABLE_DEPTH));
    rep_now    = complete_q && any_hit;
    ovf_now    = complete_q && !any_hit && table_full;
    rep_flag   = repeat_found_q || rep_now;
    ovf_flag   = overflow_q || ovf_now;
  end

  assign load   = (state_q == rkd_pkg::ST_DEC) && (!out_valid_q || !out_stall_i);
  assign insert = load && complete_q && !any_hit && !table_full;

  // Next-state logic of the sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rkd_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = rkd_pkg::ST_CMP;
        end
      end
      rkd_pkg::ST_CMP: begin
        state_d = rkd_pkg::ST_RED;
      end
      rkd_pkg::ST_RED: begin
        state_d = rkd_pkg::ST_DEC;
      end
      rkd_pkg::ST_DEC: begin
        if (load) begin
          state_d = rkd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rkd_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and sequence state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= rkd_pkg::ST_IDLE;
      kmer_len_q     <= rkd_pkg::LEN_RESET;
      window_q       <= '0;
      bases_seen_q   <= '0;
      used_q         <= '0;
      repeat_found_q <= 1'b0;
      overflow_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        kmer_len_q <= cfg_data_i;
      end
      if (in_accept) begin
        window_q     <= win_new;
        bases_seen_q <= cnt_new;
      end
      if (load) begin
        if (last_q) begin
          window_q       <= '0;
          bases_seen_q   <= '0;
          used_q         <= '0;
          repeat_found_q <= 1'b0;
          overflow_q     <= 1'b0;
        end else begin
          if (insert) begin
            used_q <= used_q + 1'b1;
          end
          repeat_found_q <= rep_flag;
          overflow_q     <= ovf_flag;
        end
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Per-request payload and the output register.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      code_q     <= complete_new ? (win_new & code_mask) : '0;
      start_q    <= complete_new ? start_full[POS_W-1:0] : '0;
      complete_q <= complete_new;
      last_q     <= last_i;
    end
    if (load) begin
      is_repeat_o       <= rep_now;
      kmer_code_o       <= code_q;
      start_pos_o       <= start_q;
      end_of_sequence_o <= last_q;
      any_repeat_o      <= rep_flag;
      table_overflow_o  <= ovf_flag;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// ===== design/rkd_checker.sv =====
`default_nettype none
// Port-level checks of the repeated k-mer detector.
module rkd_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic                       is_repeat_o,
  input wire logic [rkd_pkg::CODE_W-1:0] kmer_code_o,
  input wire logic                       any_repeat_o
);

  // A base in work blocks the next request.
  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o
  ) else $error("input taken while a base is still in work");

  // A repeat always shows in the sequence summary flag.
  a_repeat_flagged: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_repeat_o) |-> any_repeat_o
  ) else $error("repeat reported without the summary flag");

  // A stalled result stays offered.
  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o
  ) else $error("stalled result withdrawn");

  // A stalled result keeps its k-mer.
  a_out_stable: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(kmer_code_o)
  ) else $error("stalled result changed");

endmodule

bind repeated_kmer_detector_core rkd_checker u_checker (.*);
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
`default_nettype none

module testbench;

  localparam int MAX_KMER      = 32;
  localparam int TABLE_DEPTH   = 256;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BASES  = 780;
  localparam int LONG_PHASE    = 5;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int REPORT_MAX    = 10;

  // One result of the detector, as seen on the output ports.
  typedef struct packed {
    logic                       is_repeat;
    logic [rkd_pkg::CODE_W-1:0] code;
    logic [rkd_pkg::POS_W-1:0]  start_pos;
    logic                       eos;
    logic                       any_repeat;
    logic                       overflow;
  } kmer_result_t;

  // A row of the directed plan either sends one base or rewrites the k-mer length.
  typedef enum logic {
    ROW_BASE,
    ROW_LEN
  } row_kind_e;

  typedef struct {
    row_kind_e                  kind;
    logic [rkd_pkg::BASE_W-1:0] nt;
    logic                       fin;
    logic [rkd_pkg::LEN_W-1:0]  len;
    bit                         typed;
    kmer_result_t               want;
  } stim_row_t;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [rkd_pkg::BASE_W-1:0] base = '0;
  logic                       last = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       is_repeat;
  logic [rkd_pkg::CODE_W-1:0] kmer_code;
  logic [rkd_pkg::POS_W-1:0]  start_pos;
  logic                       end_of_sequence;
  logic                       any_repeat;
  logic                       table_overflow;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [rkd_pkg::LEN_W-1:0]  cfg_data = '0;

  // Shadow copy of the detector state.
  logic [rkd_pkg::CODE_W-1:0] shift_window = '0;
  logic [rkd_pkg::CODE_W-1:0] kmer_store [TABLE_DEPTH];
  int unsigned                store_fill = 0;
  int unsigned                base_count = 0;
  logic                       hit_seen = 1'b0;
  logic                       full_seen = 1'b0;
  logic [rkd_pkg::LEN_W-1:0]  len_setting = rkd_pkg::LEN_RESET;

  kmer_result_t               pending [$];
  stim_row_t                  plan [$];
  logic [rkd_pkg::BASE_W-1:0] strand [$];

  bit steady = 1'b0;
  int stall_left = 0;
  int err_count = 0;
  int cycle_count = 0;
  int bases_sent = 0;
  int results_seen = 0;
  int repeats_seen = 0;
  int full_results = 0;
  int closed_seqs = 0;
  int len_writes = 0;

  repeated_kmer_detector_core #(
    .MAX_KMER   (MAX_KMER),
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .base_i           (base),
    .last_i           (last),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .is_repeat_o      (is_repeat),
    .kmer_code_o      (kmer_code),
    .start_pos_o      (start_pos),
    .end_of_sequence_o(end_of_sequence),
    .any_repeat_o     (any_repeat),
    .table_overflow_o (table_overflow),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Advance the shadow state by one base and return the result it should produce.
  function automatic kmer_result_t detect_step(input logic [rkd_pkg::BASE_W-1:0] nt,
                                               input logic fin);
    int unsigned  k;
    int unsigned  i;
    logic         hit;
    kmer_result_t r;
    k = len_setting;
    if (k == 0) k = 1;
    if (k > MAX_KMER) k = MAX_KMER;
    r = '0;
    hit = 1'b0;
    shift_window = {shift_window[rkd_pkg::CODE_W-3:0], nt};
    if (base_count < rkd_pkg::BASES_SEEN_MAX) base_count++;
    if (base_count >= k) begin
      r.code = (k >= 32) ? shift_window : shift_window & ((64'd1 << (2 * k)) - 64'd1);
      r.start_pos = rkd_pkg::POS_W'(base_count - k);
      for (i = 0; i < store_fill; i++) begin
        if (kmer_store[i] == r.code) hit = 1'b1;
      end
      if (hit) begin
        r.is_repeat = 1'b1;
        hit_seen = 1'b1;
      end else if (store_fill < TABLE_DEPTH) begin
        kmer_store[store_fill] = r.code;
        store_fill++;
      end else begin
        full_seen = 1'b1;
      end
    end
    r.eos = fin;
    r.any_repeat = hit_seen;
    r.overflow = full_seen;
    // The last base closes the sequence.
    if (fin) begin
      shift_window = '0;
      store_fill = 0;
      base_count = 0;
      hit_seen = 1'b0;
      full_seen = 1'b0;
    end
    return r;
  endfunction

  function automatic void add_base(input logic [rkd_pkg::BASE_W-1:0] nt, input logic fin);
    stim_row_t row;
    row.kind = ROW_BASE;
    row.nt = nt;
    row.fin = fin;
    row.len = '0;
    row.typed = 1'b0;
    row.want = '0;
    plan = {plan, row};
  endfunction

  function automatic void add_typed(input logic [rkd_pkg::BASE_W-1:0] nt, input logic fin,
                                    input logic rep,
                                    input logic [rkd_pkg::CODE_W-1:0] code,
                                    input logic [rkd_pkg::POS_W-1:0] pos, input logic eos,
                                    input logic anyr, input logic ovf);
    stim_row_t row;
    row.kind = ROW_BASE;
    row.nt = nt;
    row.fin = fin;
    row.len = '0;
    row.typed = 1'b1;
    row.want.is_repeat = rep;
    row.want.code = code;
    row.want.start_pos = pos;
    row.want.eos = eos;
    row.want.any_repeat = anyr;
    row.want.overflow = ovf;
    plan = {plan, row};
  endfunction

  function automatic void add_len(input logic [rkd_pkg::LEN_W-1:0] len);
    stim_row_t row;
    row.kind = ROW_LEN;
    row.nt = '0;
    row.fin = 1'b0;
    row.len = len;
    row.typed = 1'b0;
    row.want = '0;
    plan = {plan, row};
  endfunction

  function automatic int unsigned eff_len(input logic [rkd_pkg::LEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > MAX_KMER) return MAX_KMER;
    return len;
  endfunction

  // Fill the strand with n bases: random content with copied stretches so that
  // longer k-mers recur, or a single repeated base for a low-entropy strand.
  function automatic void build_strand(input int n, input int unsigned k, input bit mono,
                                       input logic [rkd_pkg::BASE_W-1:0] mono_base);
    int from;
    int span;
    int j;
    strand.delete();
    while (strand.size() < n) begin
      if (mono) begin
        strand = {strand, mono_base};
      end else if (strand.size() >= 4 && $urandom_range(3) == 0) begin
        from = $urandom_range(strand.size() - 1);
        span = $urandom_range(1, k + 4);
        for (j = 0; j < span && from + j < strand.size() && strand.size() < n; j++) begin
          strand = {strand, strand[from + j]};
        end
      end else begin
        strand = {strand, rkd_pkg::BASE_W'($urandom_range(3))};
      end
    end
  endfunction

  task automatic send_base(input logic [rkd_pkg::BASE_W-1:0] nt, input logic fin,
                           input bit typed, input kmer_result_t typed_want);
    kmer_result_t predicted;
    // Occasional idle gap on the input side.
    if (!steady && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
    in_valid <= 1'b1;
    base <= nt;
    last <= fin;
    do @(posedge clk); while (in_stall);
    predicted = detect_step(nt, fin);
    pending = {pending, (typed ? typed_want : predicted)};
    bases_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_len(input logic [rkd_pkg::LEN_W-1:0] len);
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    len_setting = len;
    len_writes++;
  endtask

  task automatic flag_error(input string msg);
    err_count++;
    if (err_count <= REPORT_MAX) $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Result stall: random bursts of stall, only while the bench is not in a steady phase.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(99) < 2) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin : check_results
    kmer_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (is_repeat) repeats_seen++;
      if (table_overflow) full_results++;
      if (end_of_sequence) closed_seqs++;
      if (pending.size() == 0) begin
        flag_error("result arrived with no request pending");
      end else begin
        want = pending.pop_front();
        if (is_repeat !== want.is_repeat || kmer_code !== want.code ||
            start_pos !== want.start_pos || end_of_sequence !== want.eos ||
            any_repeat !== want.any_repeat || table_overflow !== want.overflow) begin
          flag_error($sformatf({"result %0d: expected rep=%0b code=%h pos=%0d eos=%0b ",
                                "any=%0b ovf=%0b, got rep=%0b code=%h pos=%0d eos=%0b ",
                                "any=%0b ovf=%0b"}, results_seen,
                               want.is_repeat, want.code, want.start_pos, want.eos,
                               want.any_repeat, want.overflow, is_repeat, kmer_code,
                               start_pos, end_of_sequence, any_repeat, table_overflow));
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results pending.", cycle_count,
               pending.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : run
    logic [rkd_pkg::LEN_W-1:0] len_picks [12];
    logic [rkd_pkg::LEN_W-1:0] lenv;
    int unsigned      k;
    int               phase;
    int               random_start;
    int               nseq;
    int               n;
    int               s;
    int               j;
    int               base_j;
    bit               open_seq;
    bit               did_all_t;
    kmer_result_t     none;

    len_picks = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd32, 6'd7, 6'd12, 6'd20, 6'd31, 6'd33,
                  6'd63};
    none = '0;
    did_all_t = 1'b0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed plan. After reset the length is ten, so the first k-mers are incomplete.
    add_typed(2'd3, 1'b0, 1'b0, 64'd0, 8'd0, 1'b0, 1'b0, 1'b0);
    add_typed(2'd0, 1'b1, 1'b0, 64'd0, 8'd0, 1'b1, 1'b0, 1'b0);
    // A length of zero behaves as one: every base is its own k-mer.
    add_len(6'd0);
    add_typed(2'd0, 1'b0, 1'b0, 64'd0, 8'd0, 1'b0, 1'b0, 1'b0);
    add_typed(2'd3, 1'b0, 1'b0, 64'd3, 8'd1, 1'b0, 1'b0, 1'b0);
    add_typed(2'd0, 1'b0, 1'b1, 64'd0, 8'd2, 1'b0, 1'b1, 1'b0);
    add_typed(2'd3, 1'b1, 1'b1, 64'd3, 8'd3, 1'b1, 1'b1, 1'b0);
    // Length two: C G C G repeats the dimer CG.
    add_len(6'd2);
    add_typed(2'd1, 1'b0, 1'b0, 64'd0, 8'd0, 1'b0, 1'b0, 1'b0);
    add_typed(2'd2, 1'b0, 1'b0, 64'd6, 8'd0, 1'b0, 1'b0, 1'b0);
    add_typed(2'd1, 1'b0, 1'b0, 64'd9, 8'd1, 1'b0, 1'b0, 1'b0);
    add_typed(2'd2, 1'b1, 1'b1, 64'd6, 8'd2, 1'b1, 1'b1, 1'b0);
    // An oversized length clamps to the maximum; then the length changes mid-sequence
    // and codes stored under one length are matched under another.
    add_len(6'd63);
    add_base(2'd2, 1'b0);
    add_base(2'd1, 1'b0);
    add_len(6'd1);
    add_base(2'd1, 1'b0);
    add_base(2'd1, 1'b0);
    add_len(6'd2);
    add_base(2'd0, 1'b0);
    add_base(2'd1, 1'b0);
    add_len(6'd33);
    add_base(2'd3, 1'b1);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_LEN) begin
        drain_results();
        write_len(plan[i].len);
      end else begin
        send_base(plan[i].nt, plan[i].fin, plan[i].typed, plan[i].want);
      end
    end

    // Random phases: one length per phase and one to three sequences each, but one long sequence in the long phase.
    random_start = bases_sent;
    phase = 0;
    while (bases_sent - random_start < RANDOM_BASES) begin
      drain_results();
      if (phase == LONG_PHASE) begin
        // One long sequence with no idling: it fills the table, drops new k-mers,
        // repeats dropped and stored stretches, and runs the base counter into its limit.
        steady = 1'b1;
        write_len(6'd32);
        build_strand(400, 32, 1'b0, 2'd0);
        for (j = 0; j < 60; j++) strand = {strand, strand[300 + j]};
        for (j = 0; j < 40; j++) strand = {strand, strand[j]};
        for (j = 0; j < 30; j++) strand = {strand, rkd_pkg::BASE_W'($urandom_range(3))};
        for (j = 0; j < strand.size(); j++) begin
          send_base(strand[j], j == strand.size() - 1, 1'b0, none);
        end
        steady = 1'b0;
      end else begin
        lenv = (phase < 12) ? len_picks[phase] :
               ($urandom_range(3) == 0) ? rkd_pkg::LEN_W'($urandom_range(63)) :
                                          rkd_pkg::LEN_W'($urandom_range(8, 1));
        write_len(lenv);
        k = eff_len(lenv);
        nseq = $urandom_range(3, 1);
        for (s = 0; s < nseq; s++) begin
          n = ($urandom_range(99) < 60) ? $urandom_range(k + 12, 1) : $urandom_range(8, 1);
          if (k == MAX_KMER && !did_all_t) begin
            // All-T strand gives the all-ones code at the longest length.
            build_strand(k + 2, k, 1'b1, 2'd3);
            did_all_t = 1'b1;
          end else begin
            build_strand(n, k, $urandom_range(99) < 10,
                         rkd_pkg::BASE_W'($urandom_range(3)));
          end
          // Now and then the last sequence of a phase is left open across the next write.
          open_seq = (s == nseq - 1) && ($urandom_range(99) < 15);
          base_j = $urandom_range(strand.size() - 1);
          for (j = 0; j < strand.size(); j++) begin
            if (j == base_j && $urandom_range(99) < 5) drain_results();
            send_base(strand[j], (j == strand.size() - 1) && !open_seq, 1'b0, none);
          end
        end
      end
      phase++;
    end

    drain_results();
    if (pending.size() != 0) begin
      flag_error($sformatf("%0d expected results never arrived", pending.size()));
    end

    $display("Covered %0d bases in %0d closed sequences under %0d length writes.",
             bases_sent, closed_seqs, len_writes);
    $display("Checked %0d results: %0d repeats, %0d with the table full; %0d errors.",
             results_seen, repeats_seen, full_results, err_count);
    if (err_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/rkd_pkg.sv
design/rkd_cell.sv
design/rkd_hit_reduce.sv
design/repeated_kmer_detector_core.sv
design/rkd_checker.sv
tb/testbench.sv
